### hw/rtl/smsup_pkg.sv
// ----------------------------------------------------------------------------
// Sensor measurement supervisor package
// Payload structures, configuration bundle, codes and reset values shared by
// the configuration registers, the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package smsup_pkg;

  // Event kinds carried by an input request.
  typedef enum logic [1:0] {
    KIND_POLL       = 2'd0,
    KIND_START      = 2'd1,
    KIND_RECOVER    = 2'd2,
    KIND_INVALIDATE = 2'd3
  } kind_t;

  // Device state as reported to the user.
  typedef enum logic [2:0] {
    ST_NOT_FOUND  = 3'd0,
    ST_STARTING   = 3'd1,
    ST_READY      = 3'd2,
    ST_ERROR      = 3'd3,
    ST_RECOVERING = 3'd4
  } dev_state_t;

  // Phase of the measurement cycle.
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_MEASURING = 2'd1,
    PH_BETWEEN   = 2'd2
  } phase_t;

  // Bus transaction outcome codes.
  localparam logic [2:0] CODE_OK        = 3'd0;
  localparam logic [2:0] CODE_BUS       = 3'd1;
  localparam logic [2:0] CODE_NOT_READY = 3'd2;
  localparam logic [2:0] CODE_NOT_FOUND = 3'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_FAIL_LIMIT      = 3'd0;
  localparam logic [2:0] REG_STALE_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_MEASURE_INTERVAL = 3'd2;
  localparam logic [2:0] REG_CONVERSION_TIME = 3'd3;
  localparam logic [2:0] REG_BACKOFF_FIRST   = 3'd4;
  localparam logic [2:0] REG_BACKOFF_SECOND  = 3'd5;
  localparam logic [2:0] REG_BACKOFF_THIRD   = 3'd6;
  localparam logic [2:0] REG_BACKOFF_CAP     = 3'd7;

  // Configuration reset values.
  localparam logic [7:0]  RST_FAIL_LIMIT       = 8'd3;
  localparam logic [31:0] RST_STALE_TIMEOUT    = 32'd10000;
  localparam logic [31:0] RST_MEASURE_INTERVAL = 32'd1000;
  localparam logic [15:0] RST_CONVERSION_TIME  = 16'd10;
  localparam logic [31:0] RST_BACKOFF_FIRST    = 32'd5000;
  localparam logic [31:0] RST_BACKOFF_SECOND   = 32'd10000;
  localparam logic [31:0] RST_BACKOFF_THIRD    = 32'd30000;
  localparam logic [31:0] RST_BACKOFF_CAP      = 32'd60000;

  // Saturation limit of the run counters.
  localparam logic [7:0] RUN_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [2:0]  probe_status;
    logic [2:0]  begin_status;
    logic [2:0]  finish_status;
    logic        sample_ok;
  } sms_in_t;

  typedef struct packed {
    logic [2:0]  device_state;
    logic        sample_valid;
    logic        accept_sample;
    logic        did_probe;
    logic        did_begin;
    logic        did_finish;
    logic [2:0]  call_status;
    logic [2:0]  last_error;
    logic [7:0]  error_run;
    logic        probe_due;
    logic [31:0] recoveries;
  } sms_out_t;

  typedef struct packed {
    logic [7:0]  fail_limit;
    logic [31:0] stale_timeout_ms;
    logic [31:0] measure_interval_ms;
    logic [15:0] conversion_time_ms;
    logic [31:0] backoff_first_ms;
    logic [31:0] backoff_second_ms;
    logic [31:0] backoff_third_ms;
    logic [31:0] backoff_cap_ms;
  } sms_cfg_t;

endpackage

`default_nettype wire

### hw/rtl/smsup_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sensor measurement supervisor configuration registers
// Holds the eight timing and threshold registers written over the
// configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module smsup_cfg_regs
  import smsup_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [31:0] wr_data,
  output sms_cfg_t         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fail_limit          <= RST_FAIL_LIMIT;
      cfg.stale_timeout_ms    <= RST_STALE_TIMEOUT;
      cfg.measure_interval_ms <= RST_MEASURE_INTERVAL;
      cfg.conversion_time_ms  <= RST_CONVERSION_TIME;
      cfg.backoff_first_ms    <= RST_BACKOFF_FIRST;
      cfg.backoff_second_ms   <= RST_BACKOFF_SECOND;
      cfg.backoff_third_ms    <= RST_BACKOFF_THIRD;
      cfg.backoff_cap_ms      <= RST_BACKOFF_CAP;
    end else if (wr_en) begin
      case (wr_index)
        REG_FAIL_LIMIT:       cfg.fail_limit          <= wr_data[7:0];
        REG_STALE_TIMEOUT:    cfg.stale_timeout_ms    <= wr_data;
        REG_MEASURE_INTERVAL: cfg.measure_interval_ms <= wr_data;
        REG_CONVERSION_TIME:  cfg.conversion_time_ms  <= wr_data[15:0];
        REG_BACKOFF_FIRST:    cfg.backoff_first_ms    <= wr_data;
        REG_BACKOFF_SECOND:   cfg.backoff_second_ms   <= wr_data;
        REG_BACKOFF_THIRD:    cfg.backoff_third_ms    <= wr_data;
        REG_BACKOFF_CAP:      cfg.backoff_cap_ms      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/smsup_step.sv
// ----------------------------------------------------------------------------
// Sensor measurement supervisor step logic
// Supervisor state registers and the single-pass update that one event
// applies to them, producing the result of that event.
// ----------------------------------------------------------------------------
`default_nettype none

module smsup_step
  import smsup_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  sms_in_t       item,
  input  sms_cfg_t      cfg,
  output sms_out_t      result
);

  // Supervisor state.
  dev_state_t  mode;
  phase_t      step_phase;
  logic        valid_flag;
  logic [31:0] read_deadline;
  logic [31:0] good_sample_time;
  logic [7:0]  fail_run;
  logic [7:0]  absent_run;
  logic [31:0] next_probe_time;
  logic [2:0]  error_class;
  logic [31:0] recover_total;

  dev_state_t  mode_next;
  phase_t      step_phase_next;
  logic        valid_flag_next;
  logic [31:0] read_deadline_next;
  logic [31:0] good_sample_time_next;
  logic [7:0]  fail_run_next;
  logic [7:0]  absent_run_next;
  logic [31:0] next_probe_time_next;
  logic [2:0]  error_class_next;
  logic [31:0] recover_total_next;

  logic        accept;
  logic        dprobe;
  logic        dbegin;
  logic        dfinish;
  logic [2:0]  cstat;
  logic [31:0] sample_age;
  logic [31:0] conv_deadline;
  logic [31:0] backoff;
  logic        probe_window_open;

  // True once now has reached t, taken modulo 2^32 over half the range.
  function automatic logic time_reached(input logic [31:0] now, input logic [31:0] t);
    logic [31:0] diff;
    diff = now - t;
    return !diff[31];
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == RUN_MAX) ? v : v + 8'd1;
  endfunction

  assign sample_age        = item.now_ms - good_sample_time;
  assign conv_deadline     = item.now_ms + {16'd0, cfg.conversion_time_ms};
  assign probe_window_open = time_reached(item.now_ms, next_probe_time);

  // Backoff ladder indexed by the absence count after its increment.
  always_comb begin
    case (sat_inc(absent_run))
      8'd0, 8'd1: backoff = cfg.backoff_first_ms;
      8'd2:       backoff = cfg.backoff_second_ms;
      8'd3:       backoff = cfg.backoff_third_ms;
      default:    backoff = cfg.backoff_cap_ms;
    endcase
  end

  always_comb begin
    mode_next             = mode;
    step_phase_next       = step_phase;
    valid_flag_next       = valid_flag;
    read_deadline_next    = read_deadline;
    good_sample_time_next = good_sample_time;
    fail_run_next         = fail_run;
    absent_run_next       = absent_run;
    next_probe_time_next  = next_probe_time;
    error_class_next      = error_class;
    recover_total_next    = recover_total;
    accept  = 1'b0;
    dprobe  = 1'b0;
    dbegin  = 1'b0;
    dfinish = 1'b0;
    cstat   = CODE_OK;

    case (kind_t'(item.kind))
      KIND_POLL: begin
        if (mode == ST_STARTING || mode == ST_READY) begin
          if (valid_flag && sample_age >= cfg.stale_timeout_ms) begin
            valid_flag_next = 1'b0;
          end
          if (fail_run >= cfg.fail_limit) begin
            step_phase_next = PH_IDLE;
            valid_flag_next = 1'b0;
            mode_next       = ST_ERROR;
          end else if (mode == ST_STARTING) begin
            if (step_phase == PH_MEASURING && time_reached(item.now_ms, read_deadline)) begin
              dfinish         = 1'b1;
              step_phase_next = PH_IDLE;
              if (item.finish_status != CODE_OK) begin
                error_class_next = item.finish_status;
                if (item.finish_status == CODE_BUS) begin
                  // A bus error on the read retries the measure command once.
                  fail_run_next = sat_inc(fail_run);
                  if (fail_run_next >= cfg.fail_limit) begin
                    valid_flag_next = 1'b0;
                    mode_next       = ST_ERROR;
                  end else begin
                    dbegin = 1'b1;
                    if (item.begin_status != CODE_OK) begin
                      error_class_next = item.begin_status;
                      fail_run_next    = sat_inc(fail_run_next);
                      if (fail_run_next >= cfg.fail_limit) begin
                        step_phase_next = PH_IDLE;
                        valid_flag_next = 1'b0;
                        mode_next       = ST_ERROR;
                      end
                    end else begin
                      read_deadline_next = conv_deadline;
                      step_phase_next    = PH_MEASURING;
                      mode_next          = ST_STARTING;
                    end
                  end
                end else if (item.finish_status == CODE_NOT_READY) begin
                  read_deadline_next = conv_deadline;
                  step_phase_next    = PH_MEASURING;
                  mode_next          = ST_STARTING;
                end else begin
                  fail_run_next = sat_inc(fail_run);
                  if (fail_run_next >= cfg.fail_limit) begin
                    step_phase_next = PH_IDLE;
                    valid_flag_next = 1'b0;
                    mode_next       = ST_ERROR;
                  end
                end
              end else if (item.sample_ok) begin
                accept                = 1'b1;
                valid_flag_next       = 1'b1;
                good_sample_time_next = item.now_ms;
                mode_next             = ST_READY;
                step_phase_next       = PH_BETWEEN;
                error_class_next      = CODE_OK;
                fail_run_next         = 8'd0;
              end
            end
          end else if (step_phase == PH_BETWEEN && sample_age >= cfg.measure_interval_ms) begin
            dbegin = 1'b1;
            if (item.begin_status != CODE_OK) begin
              error_class_next = item.begin_status;
              fail_run_next    = sat_inc(fail_run);
              if (fail_run_next >= cfg.fail_limit) begin
                step_phase_next = PH_IDLE;
                valid_flag_next = 1'b0;
                mode_next       = ST_ERROR;
              end
            end else begin
              read_deadline_next = conv_deadline;
              step_phase_next    = PH_MEASURING;
              mode_next          = ST_STARTING;
            end
          end
        end
      end

      KIND_START: begin
        if (absent_run != 8'd0 && !probe_window_open) begin
          mode_next = ST_NOT_FOUND;
          cstat     = CODE_NOT_FOUND;
        end else begin
          dprobe = 1'b1;
          if (item.probe_status != CODE_OK) begin
            mode_next            = ST_NOT_FOUND;
            error_class_next     = item.probe_status;
            absent_run_next      = sat_inc(absent_run);
            next_probe_time_next = item.now_ms + backoff;
            cstat                = item.probe_status;
          end else begin
            absent_run_next  = 8'd0;
            error_class_next = CODE_OK;
            dbegin           = 1'b1;
            if (item.begin_status != CODE_OK) begin
              fail_run_next    = sat_inc(fail_run);
              error_class_next = item.begin_status;
              if (fail_run_next >= cfg.fail_limit) begin
                mode_next = ST_ERROR;
              end
              cstat = item.begin_status;
            end else begin
              read_deadline_next = conv_deadline;
              step_phase_next    = PH_MEASURING;
              mode_next          = ST_STARTING;
            end
          end
        end
      end

      KIND_RECOVER: begin
        recover_total_next = recover_total + 32'd1;
        fail_run_next      = 8'd0;
        valid_flag_next    = 1'b0;
        step_phase_next    = PH_IDLE;
        mode_next          = ST_RECOVERING;
      end

      default: begin
        valid_flag_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.device_state  = mode_next;
    result.sample_valid  = valid_flag_next;
    result.accept_sample = accept;
    result.did_probe     = dprobe;
    result.did_begin     = dbegin;
    result.did_finish    = dfinish;
    result.call_status   = cstat;
    result.last_error    = error_class_next;
    result.error_run     = fail_run_next;
    result.probe_due     = (absent_run_next == 8'd0) ||
                           time_reached(item.now_ms, next_probe_time_next);
    result.recoveries    = recover_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= ST_NOT_FOUND;
      step_phase       <= PH_IDLE;
      valid_flag       <= 1'b0;
      read_deadline    <= 32'd0;
      good_sample_time <= 32'd0;
      fail_run         <= 8'd0;
      absent_run       <= 8'd0;
      next_probe_time  <= 32'd0;
      error_class      <= CODE_OK;
      recover_total    <= 32'd0;
    end else if (en) begin
      mode             <= mode_next;
      step_phase       <= step_phase_next;
      valid_flag       <= valid_flag_next;
      read_deadline    <= read_deadline_next;
      good_sample_time <= good_sample_time_next;
      fail_run         <= fail_run_next;
      absent_run       <= absent_run_next;
      next_probe_time  <= next_probe_time_next;
      error_class      <= error_class_next;
      recover_total    <= recover_total_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sensor_measurement_supervisor_top.sv
// ----------------------------------------------------------------------------
// Sensor measurement supervisor
// Tracks one single-shot sensor through probe, conversion, read and recovery
// events, and reports device state and sample validity for every event.
//
//   Channel   Direction  Handshake            Payload
//   in        to block   in_valid/in_ready    in_data   (sms_in_t)
//   out       from block out_valid/out_ready  out_data  (sms_out_t)
//   cfg       to block   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event is taken per clock cycle while the output is not stalled. A
// request is held in the input register while it is evaluated, and its result
// is written to the output register when that register is free or is being
// emptied. The rate is set by the single pass of update logic between the two
// registers, which reads and writes the supervisor state once per event.
// Reset is synchronous: it empties both registers, clears the supervisor
// state and loads the default configuration. A stalled output holds its
// result while the input register keeps one further request waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_measurement_supervisor_top
  import smsup_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  sms_in_t          in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sms_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Input register holding the request that is being evaluated.
  logic     s1_valid;
  sms_in_t  s1_item;

  // The evaluated request moves on whenever the output register is free or
  // is being emptied in this cycle.
  logic     advance;
  logic     fire;

  sms_cfg_t cfg;
  sms_out_t step_result;

  assign advance   = !out_valid || out_ready;
  assign fire      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;

  // Configuration writes are always taken; the user must ensure they arrive only while idle.
  assign cfg_ready = 1'b1;

  smsup_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The state registers live with the update logic and change only when the
  // request in the input register is handed to the output register.
  smsup_step u_step (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= step_result;
    end
  end

  // A committed sample always leaves the device ready with a valid sample.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accept_sample |->
      out_data.device_state == ST_READY && out_data.sample_valid)
    else $error("accepted sample without ready state and valid flag");

  // A result read comes only from a poll, a probe only from a start request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.did_finish |-> !out_data.did_probe &&
      out_data.call_status == CODE_OK)
    else $error("read reported together with start request outputs");

  // With the output register empty the block must take a new request.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  // A result is presented in the cycle after its request was evaluated.
  assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("evaluated request produced no result");

endmodule

`default_nettype wire
